// ===== rtl/rotary_encoder_click_decoder_defines.svh =====
// Assertion helpers for the checker file.
`ifndef ROTARY_ENCODER_CLICK_DECODER_DEFINES_SVH
`define ROTARY_ENCODER_CLICK_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RECD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RECD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/recd_pkg.sv =====
package recd_pkg;

    // Counter width for press, gap and repeat counters.
    localparam int COUNT_WIDTH = 14;
    // Width of the tick-count configuration registers.
    localparam int CFG_W       = 14;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int CFG_IDX_W   = 3;
    localparam int MODE_W      = 3;
    localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH + 1);

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [CFG_W-1:0]       cfg_t;
    typedef logic [CMP_W-1:0]       cmp_t;
    typedef logic [MODE_W-1:0]      mode_t;

    localparam cnt_t CNT_MAX = '1;
    localparam int PRESS_CAP_INT = (((1 << COUNT_WIDTH) - 1) < 10000) ?
                                   ((1 << COUNT_WIDTH) - 1) : 10000;
    localparam cnt_t PRESS_CAP = PRESS_CAP_INT[COUNT_WIDTH-1:0];

    // Register reset values.
    localparam logic RST_DETENT_MODE = 1'b0;
    localparam cfg_t RST_DEBOUNCE    = 14'd20;
    localparam cfg_t RST_DOUBLE      = 14'd200;
    localparam cfg_t RST_LONG        = 14'd1000;
    localparam cfg_t RST_REPEAT      = 14'd100;

    // Mode stepping constants.
    localparam mode_t MODE_RESET       = 3'd0;
    localparam mode_t MODE_SHORT_FIRST = 3'd1;
    localparam mode_t MODE_SHORT_LIMIT = 3'd4;
    localparam mode_t MODE_DBL_A       = 3'd4;
    localparam mode_t MODE_DBL_B       = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETENT_MODE = 3'd0,
        REG_DEBOUNCE    = 3'd1,
        REG_DOUBLE      = 3'd2,
        REG_LONG        = 3'd3,
        REG_REPEAT      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2
    } rot_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_SHORT        = 3'd1,
        EV_DOUBLE       = 3'd2,
        EV_LONG_RELEASE = 3'd3,
        EV_REPEAT       = 3'd4
    } key_ev_t;

    typedef enum logic [1:0] {
        DBL_IDLE   = 2'd0,
        DBL_ARMED  = 2'd1,
        DBL_SECOND = 2'd2
    } dbl_t;

    function automatic cmp_t cmp_cnt(cnt_t v);
        return cmp_t'(v);
    endfunction

    function automatic cmp_t cmp_cfg(cfg_t v);
        return cmp_t'(v);
    endfunction

endpackage

// ===== rtl/rotary_encoder_click_decoder.sv =====
// Rotary encoder and push-key click decoder.
//
// Input channel (s_valid/s_ready): one beat per sample tick carrying the
// encoder pins s_pin_a, s_pin_b and the active-low key s_key_n.
// Result channel (m_valid/m_ready): exactly one beat per input beat with the
// rotation step, the key event and the current mode number.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 detent
// mode, 1 debounce, 2 double-click gap, 3 long press, 4 repeat period).
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle outside stalls and rebuilds; the tick is
// decoded by a single pass of compare and counter logic between the state
// registers and the result register, so a new beat is taken in the same
// cycle the previous result leaves. A write to the repeat period register
// starts a remainder unit (one quotient bit per cycle) that rebuilds the
// repeat phase; s_ready stays low while the unit is busy.
// Reset: all counters, flags and the mode clear, registers take their
// defaults, no result is pending.
// Stall: when m_ready is low the result register holds its beat, and one
// more input beat is taken only once the slot is free in the same cycle.
module rotary_encoder_click_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [recd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [recd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_pin_a,
    input  logic                                s_pin_b,
    input  logic                                s_key_n,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_rotation,
    output logic [2:0]                          m_key_event,
    output logic [recd_pkg::MODE_W-1:0]         m_mode_number
);

    // Configuration registers.
    logic                  detent_mode_reg;
    recd_pkg::cfg_t        debounce_reg;
    recd_pkg::cfg_t        double_reg;
    recd_pkg::cfg_t        long_reg;
    recd_pkg::cfg_t        repeat_reg;

    // Decoder state.
    logic                  a_prev_reg, a_prev_next;
    recd_pkg::cnt_t        press_reg, press_next;
    recd_pkg::cnt_t        gap_reg, gap_next;
    logic                  short_reg, short_next;
    logic                  long_flag_reg, long_next;
    recd_pkg::dbl_t        dbl_reg, dbl_next;
    recd_pkg::cnt_t        rcnt_reg, rcnt_next;
    // rrem_reg tracks rcnt_reg modulo the effective repeat period.
    recd_pkg::cfg_t        rrem_reg, rrem_next;
    recd_pkg::mode_t       mode_reg, mode_next;

    // Result register.
    logic                  m_valid_reg;
    recd_pkg::rot_t        rot_reg, rot_next;
    recd_pkg::key_ev_t     ev_reg, ev_next;

    // Remainder unit.
    logic                          div_busy_reg;
    logic [recd_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    recd_pkg::cnt_t                div_shift_reg;
    recd_pkg::cfg_t                div_rem_reg;
    logic [recd_pkg::CFG_W:0]      div_trial;
    logic [recd_pkg::CFG_W:0]      div_diff;
    recd_pkg::cfg_t                div_step;

    logic                          accept;
    recd_pkg::cfg_t                period;
    logic [recd_pkg::COUNT_WIDTH:0] cnt_inc;
    logic [recd_pkg::CFG_W:0]      rem_inc;
    logic                          rep_fire;

    // Free the input when the slot is empty or drains and the divider is idle.
    assign s_ready = (!m_valid_reg || m_ready) && !div_busy_reg;
    assign accept  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_rotation    = rot_reg;
    assign m_key_event   = ev_reg;
    assign m_mode_number = mode_reg;

    // A repeat period of zero behaves as one.
    assign period   = (repeat_reg == '0) ? recd_pkg::cfg_t'(1) : repeat_reg;
    // Repeat fires when the incremented count wraps to zero or hits a multiple.
    assign cnt_inc  = {1'b0, rcnt_reg} + 1'b1;
    assign rem_inc  = {1'b0, rrem_reg} + 1'b1;
    assign rep_fire = cnt_inc[recd_pkg::COUNT_WIDTH] || (rem_inc == {1'b0, period});

    // One restoring step: shift in the next count bit, subtract if it fits.
    assign div_trial = {div_rem_reg, div_shift_reg[recd_pkg::COUNT_WIDTH-1]};
    assign div_diff  = div_trial - {1'b0, period};
    assign div_step  = (div_trial >= {1'b0, period}) ? div_diff[recd_pkg::CFG_W-1:0]
                                                     : div_trial[recd_pkg::CFG_W-1:0];

    // Tick decode: rotation first, then the key qualifier, then the events in
    // the order short, double, repeat, long release; the last one wins.
    always_comb begin
        recd_pkg::mode_t mode_inc;
        a_prev_next = a_prev_reg;
        rot_next    = recd_pkg::ROT_NONE;
        press_next  = press_reg;
        gap_next    = gap_reg;
        short_next  = short_reg;
        long_next   = long_flag_reg;
        dbl_next    = dbl_reg;
        rcnt_next   = rcnt_reg;
        rrem_next   = rrem_reg;
        mode_next   = mode_reg;
        ev_next     = recd_pkg::EV_NONE;
        mode_inc    = '0;

        // Step on A falling (any A edge if detent); history moves only then.
        if (s_pin_a != a_prev_reg) begin
            a_prev_next = s_pin_a;
            if (!detent_mode_reg) begin
                if (!s_pin_a) begin
                    rot_next = s_pin_b ? recd_pkg::ROT_CW : recd_pkg::ROT_CCW;
                end
            end else if (s_pin_a) begin
                rot_next = !s_pin_b ? recd_pkg::ROT_CW : recd_pkg::ROT_CCW;
            end else begin
                rot_next = s_pin_b ? recd_pkg::ROT_CW : recd_pkg::ROT_CCW;
            end
        end

        if (!s_key_n) begin
            // Key held: mute rotation, advance the saturating press count.
            rot_next = recd_pkg::ROT_NONE;
            if (press_next < recd_pkg::PRESS_CAP) begin
                press_next = press_next + 1'b1;
            end
            if (recd_pkg::cmp_cnt(press_next) == recd_pkg::cmp_cfg(debounce_reg)) begin
                short_next = 1'b1;
            end
            if (gap_next != '0 &&
                recd_pkg::cmp_cnt(gap_next) <= recd_pkg::cmp_cfg(double_reg)) begin
                dbl_next = recd_pkg::DBL_ARMED;
            end
            if (recd_pkg::cmp_cnt(press_next) == recd_pkg::cmp_cfg(long_reg)) begin
                long_next  = 1'b1;
                short_next = 1'b0;
            end
        end else if (recd_pkg::cmp_cnt(press_next) < recd_pkg::cmp_cfg(debounce_reg)) begin
            // Bounce or idle release: drop everything.
            press_next = '0;
            short_next = 1'b0;
            long_next  = 1'b0;
            dbl_next   = recd_pkg::DBL_IDLE;
            gap_next   = '0;
        end else begin
            // Released after a valid press: time the gap for a second click.
            if (short_next) begin
                if (dbl_next == recd_pkg::DBL_IDLE && gap_next < recd_pkg::CNT_MAX) begin
                    gap_next = gap_next + 1'b1;
                end
                if (dbl_next == recd_pkg::DBL_ARMED &&
                    recd_pkg::cmp_cnt(gap_next) <= recd_pkg::cmp_cfg(double_reg)) begin
                    dbl_next = recd_pkg::DBL_SECOND;
                end
                if (dbl_next == recd_pkg::DBL_IDLE &&
                    recd_pkg::cmp_cnt(gap_next) > recd_pkg::cmp_cfg(double_reg)) begin
                    short_next = 1'b0;
                end
            end
            long_next = 1'b0;
        end

        if (recd_pkg::cmp_cnt(press_next) > recd_pkg::cmp_cfg(debounce_reg)) begin
            // Short click: step mode through 1..3.
            if (!short_next &&
                recd_pkg::cmp_cnt(gap_next) > recd_pkg::cmp_cfg(double_reg) &&
                recd_pkg::cmp_cnt(press_next) < recd_pkg::cmp_cfg(long_reg)) begin
                mode_inc  = mode_next + 1'b1;
                mode_next = (mode_inc >= recd_pkg::MODE_SHORT_LIMIT) ?
                            recd_pkg::MODE_SHORT_FIRST : mode_inc;
                ev_next    = recd_pkg::EV_SHORT;
                press_next = '0;
                gap_next   = '0;
                dbl_next   = recd_pkg::DBL_IDLE;
            end
            // Double click: toggle between the two upper modes.
            if (dbl_next == recd_pkg::DBL_SECOND && gap_next != '0 &&
                recd_pkg::cmp_cnt(gap_next) <= recd_pkg::cmp_cfg(double_reg)) begin
                mode_next  = (mode_next == recd_pkg::MODE_DBL_A) ?
                             recd_pkg::MODE_DBL_B : recd_pkg::MODE_DBL_A;
                ev_next    = recd_pkg::EV_DOUBLE;
                press_next = '0;
                gap_next   = '0;
                short_next = 1'b0;
                dbl_next   = recd_pkg::DBL_IDLE;
            end
            // Long press held: emit repeat beats every period.
            if (long_next &&
                recd_pkg::cmp_cnt(press_next) >= recd_pkg::cmp_cfg(long_reg)) begin
                if (rep_fire) begin
                    rcnt_next = '0;
                    rrem_next = '0;
                    ev_next   = recd_pkg::EV_REPEAT;
                end else begin
                    rcnt_next = cnt_inc[recd_pkg::COUNT_WIDTH-1:0];
                    rrem_next = rem_inc[recd_pkg::CFG_W-1:0];
                end
            end
            // Long press released: back to mode zero.
            if (!long_next &&
                recd_pkg::cmp_cnt(press_next) >= recd_pkg::cmp_cfg(long_reg)) begin
                mode_next  = recd_pkg::MODE_RESET;
                ev_next    = recd_pkg::EV_LONG_RELEASE;
                press_next = '0;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detent_mode_reg <= recd_pkg::RST_DETENT_MODE;
            debounce_reg    <= recd_pkg::RST_DEBOUNCE;
            double_reg      <= recd_pkg::RST_DOUBLE;
            long_reg        <= recd_pkg::RST_LONG;
            repeat_reg      <= recd_pkg::RST_REPEAT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                recd_pkg::REG_DETENT_MODE: detent_mode_reg <= cfg_wdata[0];
                recd_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_wdata;
                recd_pkg::REG_DOUBLE:      double_reg      <= cfg_wdata;
                recd_pkg::REG_LONG:        long_reg        <= cfg_wdata;
                recd_pkg::REG_REPEAT:      repeat_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Decoder state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_prev_reg    <= 1'b0;
            press_reg     <= '0;
            gap_reg       <= '0;
            short_reg     <= 1'b0;
            long_flag_reg <= 1'b0;
            dbl_reg       <= recd_pkg::DBL_IDLE;
            rcnt_reg      <= '0;
            rrem_reg      <= '0;
            mode_reg      <= recd_pkg::MODE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                a_prev_reg    <= a_prev_next;
                press_reg     <= press_next;
                gap_reg       <= gap_next;
                short_reg     <= short_next;
                long_flag_reg <= long_next;
                dbl_reg       <= dbl_next;
                rcnt_reg      <= rcnt_next;
                rrem_reg      <= rrem_next;
                mode_reg      <= mode_next;
                m_valid_reg   <= 1'b1;
            end else begin
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
                // Last remainder step: load the rebuilt repeat phase.
                if (div_busy_reg && div_cnt_reg == recd_pkg::DIV_CNT_W'(1)) begin
                    rrem_reg <= div_step;
                end
            end
        end
    end

    // Result payload needs no reset: it is qualified by m_valid_reg.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rot_reg <= rot_next;
            ev_reg  <= ev_next;
        end
    end

    // Remainder unit: rebuild rcnt mod period after the period changes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cfg_we && cfg_index == recd_pkg::REG_REPEAT) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= recd_pkg::DIV_CNT_W'(recd_pkg::COUNT_WIDTH);
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == recd_pkg::DIV_CNT_W'(1)) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cfg_we && cfg_index == recd_pkg::REG_REPEAT) begin
            div_shift_reg <= rcnt_reg;
            div_rem_reg   <= '0;
        end else if (div_busy_reg) begin
            div_shift_reg <= {div_shift_reg[recd_pkg::COUNT_WIDTH-2:0], 1'b0};
            div_rem_reg   <= div_step;
        end
    end

endmodule

// ===== rtl/recd_checker.sv =====
`include "rotary_encoder_click_decoder_defines.svh"

module recd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_key_n,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [1:0]                      m_rotation,
    input logic [2:0]                      m_key_event,
    input logic [recd_pkg::MODE_W-1:0]     m_mode_number
);

    // Stalled result beat holds.
    `RECD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_rotation) && $stable(m_key_event) && $stable(m_mode_number), "stalled result changed")

    // Every accepted tick produces a result on the next cycle.
    `RECD_ASSERT_NEXT(a_result_follows, s_valid && s_ready, m_valid, "accepted tick gave no result")

    // A held key mutes rotation.
    `RECD_ASSERT_NEXT(a_key_mutes_rot, s_valid && s_ready && !s_key_n, m_rotation == recd_pkg::ROT_NONE, "rotation reported while key held")

    // A long release always lands in mode zero.
    `RECD_ASSERT_SAME(a_long_mode, m_valid && m_key_event == recd_pkg::EV_LONG_RELEASE, m_mode_number == recd_pkg::MODE_RESET, "long release left mode nonzero")

    // A short click lands in the lower modes.
    `RECD_ASSERT_SAME(a_short_mode, m_valid && m_key_event == recd_pkg::EV_SHORT, m_mode_number != recd_pkg::MODE_RESET && m_mode_number < recd_pkg::MODE_SHORT_LIMIT, "short click mode out of range")

endmodule

bind rotary_encoder_click_decoder recd_checker u_recd_checker (.*);
